@@ src/rcg_pkg.sv @@
// Shared types and constants for the Roberts cross gradient block.
// Used by rcg_ctrl, rcg_datapath and roberts_cross_gradient; no dependencies.
package rcg_pkg;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 4096;
   localparam int CSR_WIDTH      = 11;
   localparam logic [CSR_WIDTH-1:0] WIDTH_RESET = 11'd1024;

   localparam int PIX_W  = 8;
   localparam int GRAD_W = 9;
   localparam int ROW_W  = 12;
   localparam int COL_W  = 10;
   localparam int MAG_W  = 13;
   localparam int SQ_W   = 17;
   localparam int RAD_W  = 25;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_DIFF,
      ST_SQUARE,
      ST_SUM,
      ST_ROOT,
      ST_ROUND,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic read;
      logic diff;
      logic square;
      logic sum;
      logic step;
      logic round;
      logic advance;
   } cmd_type;

   typedef struct packed {
      logic has_result;
      logic root_done;
      logic last_result;
   } status_type;

endpackage

@@ src/rcg_ctrl.sv @@
// Sequencer for the Roberts cross gradient block.
// Depends on rcg_pkg; drives rcg_datapath through cmd_type and reads status_type.
module rcg_ctrl
   import rcg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_READ;
         end
         ST_READ:   state_in = ST_DIFF;
         ST_DIFF: begin
            state_in = status.has_result ? ST_SQUARE : ST_IDLE;
         end
         ST_SQUARE: state_in = ST_SUM;
         ST_SUM:    state_in = ST_ROOT;
         ST_ROOT: begin
            if (status.root_done) state_in = ST_ROUND;
         end
         ST_ROUND:  state_in = ST_EMIT;
         ST_EMIT: begin
            if (rsp_ready && status.last_result) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_READ:   cmd.read   = 1'b1;
         ST_DIFF:   cmd.diff   = 1'b1;
         ST_SQUARE: cmd.square = 1'b1;
         ST_SUM:    cmd.sum    = 1'b1;
         ST_ROOT:   cmd.step   = 1'b1;
         ST_ROUND:  cmd.round  = 1'b1;
         ST_EMIT: begin
            rsp_valid   = 1'b1;
            cmd.advance = rsp_ready;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

@@ src/rcg_datapath.sv @@
// Datapath: line store, raster counters, differences, squares and serial root.
// Depends on rcg_pkg; sequenced by rcg_ctrl.
module rcg_datapath
   import rcg_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)(
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output status_type               status,
   input  logic                     csr_wr_en,
   input  logic [CSR_WIDTH-1:0]     csr_wr_data,
   input  logic [PIX_W-1:0]         req_pixel,
   input  logic                     req_start_of_frame,
   output logic [ROW_W-1:0]         rsp_out_row,
   output logic [COL_W-1:0]         rsp_out_col,
   output logic signed [GRAD_W-1:0] rsp_diag_grad,
   output logic signed [GRAD_W-1:0] rsp_anti_grad,
   output logic [MAG_W-1:0]         rsp_magnitude,
   output logic                     rsp_last
);

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int WW = (CW + 1 > CSR_WIDTH) ? CW + 1 : CSR_WIDTH;
   localparam int OW = (RW > ROW_W) ? RW : ROW_W;
   localparam int XW = CW + COL_W;

   logic [CSR_WIDTH-1:0]     width_ff;
   logic [CW-1:0]            col_ff, cur_col_ff;
   logic [RW-1:0]            row_ff, cur_row_ff;
   logic [PIX_W-1:0]         pixel_ff, up_ff, left_ff, ul_ff;
   logic [PIX_W-1:0]         line_mem [MAX_WIDTH];
   logic signed [GRAD_W-1:0] x_ff, y_ff;
   logic [SQ_W-1:0]          xx_ff, yy_ff;
   logic [RAD_W-1:0]         rad_ff, res_ff, bit_ff;
   logic [MAG_W-1:0]         mag_ff;
   logic [3:0]               pend_ff;

   logic [WW-1:0]            w_cfg, w_eff, next_col;
   logic                     wrap_start;
   logic [RW-1:0]            row_inc, cur_row_inc;
   logic signed [2*GRAD_W-1:0] x_sq, y_sq;
   logic [RAD_W:0]           trial;
   logic [RW-1:0]            sel_row;
   logic [CW-1:0]            sel_col;
   logic [OW-1:0]            row_ext;
   logic [XW-1:0]            col_ext;

   always_comb begin
      w_cfg = WW'(width_ff);
      if (w_cfg < WW'(2)) begin
         w_eff = WW'(2);
      end else if (w_cfg > WW'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = w_cfg;
      end
      wrap_start  = WW'(col_ff) >= w_eff;
      next_col    = WW'(cur_col_ff) + WW'(1);
      row_inc     = (row_ff == RW'(MAX_HEIGHT - 1)) ? row_ff : row_ff + RW'(1);
      cur_row_inc = (cur_row_ff == RW'(MAX_HEIGHT - 1)) ? cur_row_ff
                                                        : cur_row_ff + RW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= WIDTH_RESET;
         col_ff     <= '0;
         row_ff     <= '0;
         cur_col_ff <= '0;
         cur_row_ff <= '0;
         left_ff    <= '0;
         ul_ff      <= '0;
         pend_ff    <= '0;
         bit_ff     <= '0;
      end else begin
         if (csr_wr_en) width_ff <= csr_wr_data;
         if (cmd.load) begin
            priority if (req_start_of_frame) begin
               cur_col_ff <= '0;
               cur_row_ff <= '0;
            end else if (wrap_start) begin
               cur_col_ff <= '0;
               cur_row_ff <= row_inc;
            end else begin
               cur_col_ff <= col_ff;
               cur_row_ff <= row_ff;
            end
         end
         if (cmd.diff) begin
            if (next_col >= w_eff) begin
               col_ff <= '0;
               row_ff <= cur_row_inc;
            end else begin
               col_ff <= next_col[CW-1:0];
               row_ff <= cur_row_ff;
            end
            left_ff <= pixel_ff;
            ul_ff   <= up_ff;
            pend_ff <= {1'b1, cur_col_ff == CW'(1), cur_row_ff == RW'(1),
                        (cur_row_ff == RW'(1)) && (cur_col_ff == CW'(1))};
         end
         if (cmd.sum) begin
            bit_ff <= {1'b1, {(RAD_W-1){1'b0}}};
         end
         if (cmd.step) begin
            bit_ff <= bit_ff >> 2;
         end
         if (cmd.advance) begin
            pend_ff <= pend_ff & (pend_ff - 4'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) pixel_ff <= req_pixel;
      if (cmd.read) up_ff <= line_mem[cur_col_ff];
      if (cmd.diff) line_mem[cur_col_ff] <= pixel_ff;
   end

   assign x_sq  = x_ff * x_ff;
   assign y_sq  = y_ff * y_ff;
   assign trial = {1'b0, res_ff} + {1'b0, bit_ff};

   always_ff @(posedge clock) begin
      if (cmd.diff) begin
         x_ff <= $signed({1'b0, ul_ff}) - $signed({1'b0, pixel_ff});
         y_ff <= $signed({1'b0, up_ff}) - $signed({1'b0, left_ff});
      end
      if (cmd.square) begin
         xx_ff <= x_sq[SQ_W-1:0];
         yy_ff <= y_sq[SQ_W-1:0];
      end
      if (cmd.sum) begin
         rad_ff <= {xx_ff + yy_ff, 8'd0};
         res_ff <= '0;
      end
      if (cmd.step) begin
         if ({1'b0, rad_ff} >= trial) begin
            rad_ff <= rad_ff - trial[RAD_W-1:0];
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
      end
      if (cmd.round) begin
         mag_ff <= res_ff[MAG_W-1:0] + MAG_W'(rad_ff > res_ff);
      end
   end

   always_comb begin
      sel_row       = cur_row_ff;
      sel_col       = cur_col_ff;
      rsp_diag_grad = x_ff;
      rsp_anti_grad = y_ff;
      priority if (pend_ff[0]) begin
         sel_row       = '0;
         sel_col       = '0;
         rsp_diag_grad = -x_ff;
         rsp_anti_grad = -y_ff;
      end else if (pend_ff[1]) begin
         sel_row       = '0;
         rsp_diag_grad = -y_ff;
         rsp_anti_grad = -x_ff;
      end else if (pend_ff[2]) begin
         sel_col       = '0;
         rsp_diag_grad = y_ff;
         rsp_anti_grad = x_ff;
      end else begin
         sel_row       = cur_row_ff;
      end
      row_ext       = OW'(sel_row);
      col_ext       = XW'(sel_col);
      rsp_out_row   = (row_ext > OW'(4095)) ? {ROW_W{1'b1}} : row_ext[ROW_W-1:0];
      rsp_out_col   = col_ext[COL_W-1:0];
      rsp_magnitude = mag_ff;
      rsp_last      = (pend_ff & (pend_ff - 4'd1)) == 4'd0;
   end

   assign status.has_result  = (cur_col_ff != '0) && (cur_row_ff != '0);
   assign status.root_done   = bit_ff[0];
   assign status.last_result = rsp_last;

endmodule

@@ src/roberts_cross_gradient.sv @@
// Top level of the Roberts cross gradient block.
// Depends on rcg_pkg, rcg_ctrl and rcg_datapath.
//
// Pixels enter on the req_ channel in row-major order; req_start_of_frame
// marks row 0, column 0. Each pixel beat causes zero to four result beats on
// the rsp_ channel: diagonal and anti-diagonal differences, the magnitude in
// units of 1/16 and the row and column they belong to. rsp_last flags the
// final result caused by a pixel. Row 0 is reported while row 1 arrives and
// column 0 together with column 1 (reflect-101 border).
// One pixel is processed at a time. A pixel with no result goes through the
// line-store read and difference before the next req_ready; one with results
// goes through line-store read, difference, square, sum, 13 steps of the
// bit-serial square root (the longest part) and rounding before its first
// result beat, then gives one beat per cycle while rsp_ready is high.
// A stalled receiver holds the result steady and holds off new pixels.
// csr_wr_en writes image_width (clamped to 2..MAX_WIDTH); write it only while
// idle. Reset is synchronous: counters clear, the width returns to 1024, and
// the line store keeps no valid state until a row is written.
module roberts_cross_gradient
   import rcg_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [CSR_WIDTH-1:0]     csr_wr_data,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [PIX_W-1:0]         req_pixel,
   input  logic                     req_start_of_frame,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [ROW_W-1:0]         rsp_out_row,
   output logic [COL_W-1:0]         rsp_out_col,
   output logic signed [GRAD_W-1:0] rsp_diag_grad,
   output logic signed [GRAD_W-1:0] rsp_anti_grad,
   output logic [MAG_W-1:0]         rsp_magnitude,
   output logic                     rsp_last
);

   cmd_type    cmd;
   status_type status;

   rcg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rcg_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_pixel          (req_pixel),
      .req_start_of_frame (req_start_of_frame),
      .rsp_out_row        (rsp_out_row),
      .rsp_out_col        (rsp_out_col),
      .rsp_diag_grad      (rsp_diag_grad),
      .rsp_anti_grad      (rsp_anti_grad),
      .rsp_magnitude      (rsp_magnitude),
      .rsp_last           (rsp_last)
   );

endmodule

@@ tb/sv/tb_roberts_cross_gradient.sv @@
// Self-checking testbench for roberts_cross_gradient: drives pixel beats and
// width writes, predicts every result beat in a small scoreboard class.
// Depends on rcg_pkg and the roberts_cross_gradient RTL.

class gradient_scoreboard;
   typedef struct {
      logic [11:0]       row;
      logic [9:0]        col;
      logic signed [8:0] diag;
      logic signed [8:0] anti;
      logic [12:0]       mag;
      logic              last;
   } grad_beat_t;

   grad_beat_t  pending_q[$];
   logic [7:0]  prev_row[1024];
   int          col_now;
   int          row_now;
   logic [7:0]  left_pix;
   logic [7:0]  up_left_pix;
   int          width_reg;
   int          mismatches;
   int          beats_checked;
   int          pixels_noted;

   function new();
      foreach (prev_row[i]) prev_row[i] = '0;
      col_now = 0;
      row_now = 0;
      left_pix = '0;
      up_left_pix = '0;
      width_reg = 1024;
      mismatches = 0;
      beats_checked = 0;
      pixels_noted = 0;
   endfunction

   function void set_width(int value);
      width_reg = value & 'h7ff;
   endfunction

   function int mag_sixteenths(int d, int a);
      int v;
      int m;
      int t;
      v = (d * d + a * a) * 256;
      m = 0;
      for (int b = 13; b >= 0; b--) begin
         t = m | (1 << b);
         if (t * t <= v) m = t;
      end
      if (v - m * m > m) m++;
      return m;
   endfunction

   function void push_beat(int r, int c, int d, int a);
      grad_beat_t e;
      e.row = (r > 4095) ? 12'd4095 : r[11:0];
      e.col = c[9:0];
      e.diag = d[8:0];
      e.anti = a[8:0];
      e.mag = 13'(mag_sixteenths(d, a));
      e.last = 1'b0;
      pending_q = {pending_q, e};
   endfunction

   function void note_pixel(logic [7:0] pix, logic sof);
      int w;
      int here;
      int up;
      int ul;
      int lf;
      int n0;
      w = (width_reg < 2) ? 2 : (width_reg > 1024) ? 1024 : width_reg;
      pixels_noted++;
      if (sof) begin
         col_now = 0;
         row_now = 0;
      end else if (col_now >= w) begin
         col_now = 0;
         if (row_now < 4095) row_now++;
      end
      here = pix;
      up = prev_row[col_now];
      ul = up_left_pix;
      lf = left_pix;
      n0 = pending_q.size();
      if (col_now != 0) begin
         if (row_now == 1) begin
            if (col_now == 1) push_beat(0, 0, here - ul, lf - up);
            push_beat(0, col_now, lf - up, here - ul);
         end
         if (row_now >= 1) begin
            if (col_now == 1) push_beat(row_now, 0, up - lf, ul - here);
            push_beat(row_now, col_now, ul - here, up - lf);
         end
      end
      up_left_pix = up[7:0];
      prev_row[col_now] = pix;
      left_pix = pix;
      col_now++;
      if (col_now >= w) begin
         col_now = 0;
         if (row_now < 4095) row_now++;
      end
      if (pending_q.size() > n0) pending_q[$].last = 1'b1;
   endfunction

   function void check_beat(logic [11:0] row, logic [9:0] col, logic signed [8:0] diag,
                            logic signed [8:0] anti, logic [12:0] mag, logic last);
      grad_beat_t e;
      beats_checked++;
      if (pending_q.size() == 0) begin
         $error("unexpected result beat row %0d col %0d", row, col);
         mismatches++;
         return;
      end
      e = pending_q.pop_front();
      if (row !== e.row) begin
         $error("out_row: expected %0d, actual %0d", e.row, row);
         mismatches++;
      end
      if (col !== e.col) begin
         $error("out_col: expected %0d, actual %0d", e.col, col);
         mismatches++;
      end
      if (diag !== e.diag) begin
         $error("diag_grad: expected %0d, actual %0d", e.diag, diag);
         mismatches++;
      end
      if (anti !== e.anti) begin
         $error("anti_grad: expected %0d, actual %0d", e.anti, anti);
         mismatches++;
      end
      if (mag !== e.mag) begin
         $error("magnitude: expected %0d, actual %0d", e.mag, mag);
         mismatches++;
      end
      if (last !== e.last) begin
         $error("last: expected %0d, actual %0d", e.last, last);
         mismatches++;
      end
   endfunction
endclass

module tb_roberts_cross_gradient;
   import rcg_pkg::*;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     csr_wr_en;
   logic [CSR_WIDTH-1:0]     csr_wr_data;
   logic                     req_valid;
   logic                     req_ready;
   logic [PIX_W-1:0]         req_pixel;
   logic                     req_start_of_frame;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic [ROW_W-1:0]         rsp_out_row;
   logic [COL_W-1:0]         rsp_out_col;
   logic signed [GRAD_W-1:0] rsp_diag_grad;
   logic signed [GRAD_W-1:0] rsp_anti_grad;
   logic [MAG_W-1:0]         rsp_magnitude;
   logic                     rsp_last;

   int  send_idle;
   int  recv_idle;
   bit  hold_rsp;
   int  widths_written;

   gradient_scoreboard sb = new();

   roberts_cross_gradient u_top (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_pixel(req_pixel), .req_start_of_frame(req_start_of_frame),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_out_row(rsp_out_row), .rsp_out_col(rsp_out_col),
      .rsp_diag_grad(rsp_diag_grad), .rsp_anti_grad(rsp_anti_grad),
      .rsp_magnitude(rsp_magnitude), .rsp_last(rsp_last)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_beat(rsp_out_row, rsp_out_col, rsp_diag_grad, rsp_anti_grad,
                       rsp_magnitude, rsp_last);
      rsp_ready <= !hold_rsp && ($urandom_range(99) >= recv_idle);
   end

   initial begin
      #40_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic logic [7:0] pick_pixel();
      case ($urandom_range(7))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic send_pixel(logic [7:0] pix, logic sof);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= pix;
      req_start_of_frame <= sof;
      do @(posedge clock); while (!req_ready);
      sb.note_pixel(pix, sof);
   endtask

   // drain all expected beats, then let a pixel with no result finish
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (25) @(posedge clock);
   endtask

   task automatic write_width(int value);
      settle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value[CSR_WIDTH-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_width(value);
      widths_written++;
   endtask

   task automatic random_frames(int n_items);
      int done;
      int w;
      int total;
      done = 0;
      while (done < n_items) begin
         w = ($urandom_range(7) == 0) ? $urandom_range(9, 40) : $urandom_range(2, 8);
         write_width(w);
         total = $urandom_range(2, 5) * w;
         if ($urandom_range(9) == 0) total = $urandom_range(1, total);
         for (int k = 0; k < total; k++)
            send_pixel(pick_pixel(), k == 0 || $urandom_range(39) == 0);
         done += total;
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_valid = 1'b0;
      req_pixel = '0;
      req_start_of_frame = 1'b0;
      hold_rsp = 1'b0;
      send_idle = 0;
      recv_idle = 0;
      widths_written = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, frame cut short, width below range
      write_width(3);
      send_pixel(8'd10, 1'b1);
      send_pixel(8'd20, 1'b0);
      send_pixel(8'd255, 1'b1);
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd0, 1'b0);
      write_width(0);
      send_pixel(8'd0, 1'b1);
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd128, 1'b0);
      send_pixel(8'd1, 1'b0);

      send_idle = 12;
      recv_idle = 59;
      random_frames(70);

      // stall the receiver while pixels keep coming
      fork
         begin
            hold_rsp = 1'b1;
            repeat (400) @(posedge clock);
            hold_rsp = 1'b0;
         end
         random_frames(30);
      join

      send_idle = 59;
      recv_idle = 12;
      random_frames(50);

      send_idle = 0;
      recv_idle = 0;
      random_frames(50);

      // lower the width in the middle of a row
      write_width(8);
      for (int k = 0; k < 21; k++) send_pixel(pick_pixel(), k == 0);
      write_width(4);
      for (int k = 0; k < 14; k++) send_pixel(pick_pixel(), 1'b0);

      // width above range
      write_width(2047);
      for (int k = 0; k < 16; k++) send_pixel(pick_pixel(), k == 0);

      // width below range, narrowest rows
      write_width(1);
      for (int k = 0; k < 12; k++) send_pixel(pick_pixel(), k == 0);

      settle();
      $display("covered %0d pixel beats, %0d result beats, %0d width writes",
               sb.pixels_noted, sb.beats_checked, widths_written);
      if (sb.mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
